### hdl/heightmap_normal_generator_macros.svh
// assertion macros shared by the heightmap normal generator
// expects i_clk and i_rst_n in the scope of use
`ifndef HEIGHTMAP_NORMAL_GENERATOR_MACROS_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_MACROS_SVH

// property sampled on the rising clock, muted while reset is low
`define HNG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked in the cycle after the antecedent, muted while reset is low
`define HNG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hng_pkg.sv
// shared types and constants of the heightmap normal generator
// no dependencies
package hng_pkg;

    localparam int MAX_SIZE   = 1024;
    localparam int ADDR_W     = $clog2(MAX_SIZE);
    localparam int HEIGHT_W   = 16;
    localparam int GRID_W     = 11;
    localparam int COEF_W     = 16;
    localparam int NORM_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd2;

    localparam logic [GRID_W-1:0] GRID_RESET  = 11'd1024;
    localparam logic [COEF_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [COEF_W-1:0] CELL_RESET  = 16'd1024;

    // which grid point an item finishes
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ABOVE,
        EMIT_LEFT,
        EMIT_SELF
    } t_emit;

    // row buffer read window offset
    typedef enum logic [1:0] {
        OFS_LO,
        OFS_MID,
        OFS_HI
    } t_rd_ofs;

    typedef struct packed {
        logic    take;
        t_rd_ofs rd_ofs;
        logic    capture;
        logic    wr;
        logic    load_op;
        t_emit   emit;
        logic    out_load;
        logic    out_last;
        logic    advance;
    } t_cmd;

    typedef struct packed {
        logic has_above;
        logic has_left;
        logic has_self;
        logic norm_busy;
    } t_stat;

endpackage

### hdl/hng_norm.sv
// iterative vector normalizer: products, magnitude scaling, square root, three divisions
// depends on hng_pkg
module hng_norm import hng_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [HEIGHT_W:0] i_dx,
    input  logic signed [HEIGHT_W:0] i_dz,
    input  logic [COEF_W-1:0]        i_hscale,
    input  logic [COEF_W-1:0]        i_cell,
    output logic                     o_busy,
    output logic [NORM_W-1:0]        o_nx,
    output logic [NORM_W-1:0]        o_ny,
    output logic [NORM_W-1:0]        o_nz
);

    localparam int PROD_W = 2 * (HEIGHT_W + 1);
    localparam int ABS_W  = 32;
    localparam int MAG_W  = 30;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 64;
    localparam int LEN_W  = 31;
    localparam int Q_W    = 17;
    localparam int REM_W  = 49;

    typedef enum logic [3:0] {
        NS_IDLE, NS_MULX, NS_MULZ, NS_MAG, NS_SQ, NS_SQRT, NS_DINIT, NS_DIV, NS_SAT
    } t_nstate;

    t_nstate                  r_state;
    logic signed [PROD_W-1:0] r_px, r_pz;
    logic [MAG_W-1:0]         r_mag [3];
    logic                     r_neg_x, r_neg_z;
    logic [1:0]               r_idx;
    logic [4:0]               r_cnt;
    logic [SUM_W-1:0]         r_v;
    logic [ROOT_W-1:0]        r_res;
    logic [ROOT_W-2:0]        r_bit;
    logic [REM_W-1:0]         r_rem, r_dsh;
    logic [Q_W-1:0]           r_q;
    logic [NORM_W-1:0]        r_n [3];

    logic signed [HEIGHT_W:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0]   w_pd, w_nx, w_nz;
    logic [ABS_W-1:0]           w_ax, w_ay, w_az, w_m;
    logic [1:0]                 w_sh;
    logic [2*MAG_W-1:0]         w_sq;
    logic [ROOT_W-1:0]          w_trial;
    logic [LEN_W-1:0]           w_len;
    logic                       w_neg;
    logic [Q_W-1:0]             w_qc, w_qn;
    logic [NORM_W-1:0]          w_sat;

    // one shared multiplier for both differences
    assign w_ma = (r_state == NS_MULX) ? i_dx : i_dz;
    assign w_mb = $signed({1'b0, i_hscale});
    assign w_pd = w_ma * w_mb;

    assign w_nx = -r_px;
    assign w_nz = -r_pz;
    assign w_ax = r_px[PROD_W-1] ? w_nx[ABS_W-1:0] : r_px[ABS_W-1:0];
    assign w_az = r_pz[PROD_W-1] ? w_nz[ABS_W-1:0] : r_pz[ABS_W-1:0];
    assign w_ay = {8'd0, i_cell, 8'd0};

    always_comb begin
        w_m = w_ax;
        if (w_ay > w_m) w_m = w_ay;
        if (w_az > w_m) w_m = w_az;
        if (w_m[31])      w_sh = 2'd2;
        else if (w_m[30]) w_sh = 2'd1;
        else              w_sh = 2'd0;
    end

    assign w_sq    = r_mag[r_idx] * r_mag[r_idx];
    assign w_trial = r_res + {1'b0, r_bit};
    assign w_len   = r_res[LEN_W-1:0];

    // round-half-away quotient to q1.15 with saturation
    always_comb begin
        w_neg = ((r_idx == 2'd0) && r_neg_x) || ((r_idx == 2'd2) && r_neg_z);
        w_qc  = (r_q > 17'd32768) ? 17'd32768 : r_q;
        w_qn  = 17'd0 - w_qc;
        if (w_neg)                 w_sat = w_qn[NORM_W-1:0];
        else if (r_q > 17'd32767)  w_sat = 16'd32767;
        else                       w_sat = r_q[NORM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
        end else begin
            unique case (r_state)
                NS_IDLE: begin
                    if (i_start) r_state <= NS_MULX;
                end
                NS_MULX: begin
                    r_px    <= w_pd;
                    r_state <= NS_MULZ;
                end
                NS_MULZ: begin
                    r_pz    <= w_pd;
                    r_state <= NS_MAG;
                end
                NS_MAG: begin
                    r_mag[0] <= MAG_W'(w_ax >> w_sh);
                    r_mag[1] <= MAG_W'(w_ay >> w_sh);
                    r_mag[2] <= MAG_W'(w_az >> w_sh);
                    r_neg_x  <= r_px[PROD_W-1];
                    r_neg_z  <= r_pz[PROD_W-1];
                    r_v      <= '0;
                    r_res    <= '0;
                    r_bit    <= {1'b1, {(ROOT_W-2){1'b0}}};
                    r_idx    <= 2'd0;
                    r_cnt    <= 5'd0;
                    r_state  <= NS_SQ;
                end
                NS_SQ: begin
                    r_v <= r_v + {2'd0, w_sq};
                    if (r_idx == 2'd2) begin
                        r_state <= NS_SQRT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                NS_SQRT: begin
                    if ({2'd0, r_v} >= w_trial) begin
                        r_v   <= r_v - w_trial[SUM_W-1:0];
                        r_res <= (r_res >> 1) + {1'b0, r_bit};
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_idx   <= 2'd0;
                        r_state <= NS_DINIT;
                    end
                end
                NS_DINIT: begin
                    if (r_res == '0) begin
                        // zero length vector
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= '0;
                        r_state <= NS_IDLE;
                    end else begin
                        r_rem   <= {3'd0, r_mag[r_idx], 16'd0} + {18'd0, w_len};
                        r_dsh   <= {1'b0, w_len, 1'b0, 16'd0};
                        r_q     <= '0;
                        r_cnt   <= 5'd16;
                        r_state <= NS_DIV;
                    end
                end
                NS_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[Q_W-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[Q_W-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == 5'd0) r_state <= NS_SAT;
                    else               r_cnt   <= r_cnt - 5'd1;
                end
                NS_SAT: begin
                    r_n[r_idx] <= w_sat;
                    if (r_idx == 2'd2) begin
                        r_state <= NS_IDLE;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= NS_DINIT;
                    end
                end
                default: r_state <= NS_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != NS_IDLE);
    assign o_nx   = r_n[0];
    assign o_ny   = r_n[1];
    assign o_nz   = r_n[2];

endmodule

### hdl/hng_datapath.sv
// datapath: config registers, row buffers, position counters, operand select, output register
// depends on hng_pkg and hng_norm
module hng_datapath import hng_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [HEIGHT_W-1:0]   i_height,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_last
);

    logic [GRID_W-1:0]   r_grid;
    logic [COEF_W-1:0]   r_hscale, r_cell;
    logic [ADDR_W-1:0]   r_col, r_row, w_last;
    logic                r_sel;
    logic [HEIGHT_W-1:0] r_height;

    logic [HEIGHT_W-1:0] mem0 [MAX_SIZE];
    logic [HEIGHT_W-1:0] mem1 [MAX_SIZE];
    logic [HEIGHT_W-1:0] r_rd0, r_rd1, w_p_rd, w_b_rd;
    logic [ADDR_W-1:0]   w_p_addr, w_b_addr, w_a0, w_a1;
    logic [HEIGHT_W-1:0] r_pw [3];
    logic [HEIGHT_W-1:0] r_bw [3];

    logic                     w_col_last, w_row_last;
    logic [HEIGHT_W-1:0]      w_left, w_right, w_up, w_down;
    logic [ADDR_W-1:0]        w_pcol, w_prow;
    logic signed [HEIGHT_W:0] r_dx, r_dz;
    logic [ADDR_W-1:0]        r_pcol, r_prow;
    logic                     w_busy;
    logic [NORM_W-1:0]        w_nx, w_ny, w_nz;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic                     r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= GRID_RESET;
            r_hscale <= SCALE_RESET;
            r_cell   <= CELL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_SIZE:    r_grid   <= i_cfg_data[GRID_W-1:0];
                REG_HEIGHT_SCALE: r_hscale <= i_cfg_data;
                REG_CELL_SIZE:    r_cell   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last index of the grid, size clamped to the supported range
    always_comb begin
        if (r_grid < GRID_W'(2))             w_last = ADDR_W'(1);
        else if (r_grid > GRID_W'(MAX_SIZE)) w_last = ADDR_W'(MAX_SIZE - 1);
        else                                 w_last = ADDR_W'(r_grid - GRID_W'(1));
    end

    assign w_col_last = (r_col >= w_last);
    assign w_row_last = (r_row >= w_last);

    assign o_stat.has_above = (r_row != '0);
    assign o_stat.has_left  = w_row_last && (r_col != '0);
    assign o_stat.has_self  = w_row_last && w_col_last;
    assign o_stat.norm_busy = w_busy;

    // position counters, buffer roles swap at each row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sel <= 1'b0;
        end else if (i_cmd.advance) begin
            if (w_col_last) begin
                r_col <= '0;
                r_row <= w_row_last ? '0 : r_row + ADDR_W'(1);
                r_sel <= ~r_sel;
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_height <= i_height;
    end

    // read window: previous row at c-1..c+1, older row at c-2..c
    always_comb begin
        case (i_cmd.rd_ofs)
            OFS_MID: begin
                w_p_addr = r_col;
                w_b_addr = r_col - ADDR_W'(1);
            end
            OFS_HI: begin
                w_p_addr = r_col + ADDR_W'(1);
                w_b_addr = r_col;
            end
            default: begin
                w_p_addr = r_col - ADDR_W'(1);
                w_b_addr = r_col - ADDR_W'(2);
            end
        endcase
    end

    assign w_a0 = r_sel ? w_b_addr : w_p_addr;
    assign w_a1 = r_sel ? w_p_addr : w_b_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_sel) mem0[r_col] <= r_height;
        r_rd0 <= mem0[w_a0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !r_sel) mem1[r_col] <= r_height;
        r_rd1 <= mem1[w_a1];
    end

    assign w_p_rd = r_sel ? r_rd1 : r_rd0;
    assign w_b_rd = r_sel ? r_rd0 : r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pw[0] <= r_pw[1];
            r_pw[1] <= r_pw[2];
            r_pw[2] <= w_p_rd;
            r_bw[0] <= r_bw[1];
            r_bw[1] <= r_bw[2];
            r_bw[2] <= w_b_rd;
        end
    end

    // neighbours of the point being finished, borders fall back to the point
    always_comb begin
        case (i_cmd.emit)
            EMIT_LEFT: begin
                w_left  = (r_col == ADDR_W'(1)) ? r_bw[1] : r_bw[0];
                w_right = r_height;
                w_up    = r_pw[0];
                w_down  = r_bw[1];
                w_pcol  = r_col - ADDR_W'(1);
                w_prow  = r_row;
            end
            EMIT_SELF: begin
                w_left  = (r_col == '0) ? r_height : r_bw[1];
                w_right = r_height;
                w_up    = r_pw[1];
                w_down  = r_height;
                w_pcol  = r_col;
                w_prow  = r_row;
            end
            default: begin
                w_left  = (r_col == '0) ? r_pw[1] : r_pw[0];
                w_right = w_col_last ? r_pw[1] : r_pw[2];
                w_up    = (r_row == ADDR_W'(1)) ? r_pw[1] : r_bw[2];
                w_down  = r_height;
                w_pcol  = r_col;
                w_prow  = r_row - ADDR_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_op) begin
            r_dx   <= $signed({1'b0, w_left}) - $signed({1'b0, w_right});
            r_dz   <= $signed({1'b0, w_up}) - $signed({1'b0, w_down});
            r_pcol <= w_pcol;
            r_prow <= w_prow;
        end
    end

    hng_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.load_op),
        .i_dx     (r_dx),
        .i_dz     (r_dz),
        .i_hscale (r_hscale),
        .i_cell   (r_cell),
        .o_busy   (w_busy),
        .o_nx     (w_nx),
        .o_ny     (w_ny),
        .o_nz     (w_nz)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {4'd0, r_prow, r_pcol, w_nz, w_ny, w_nx};
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_last = r_out_last;

endmodule

### hdl/hng_ctrl.sv
// controller: item sequencing, result order and output handshake
// depends on hng_pkg
module hng_ctrl import hng_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    output logic  o_m_valid,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_SEL, ST_WAIT, ST_ADV
    } t_state;

    t_state r_state;
    t_emit  r_emit;
    logic   r_out_valid;
    t_emit  w_first, w_next;
    logic   w_out_free, w_accept;

    function automatic t_emit f_after(input t_emit e, input t_stat s);
        t_emit n;
        n = EMIT_NONE;
        case (e)
            EMIT_ABOVE: n = s.has_left ? EMIT_LEFT : (s.has_self ? EMIT_SELF : EMIT_NONE);
            EMIT_LEFT:  n = s.has_self ? EMIT_SELF : EMIT_NONE;
            default:    n = EMIT_NONE;
        endcase
        return n;
    endfunction

    assign w_first    = i_stat.has_above ? EMIT_ABOVE : f_after(EMIT_ABOVE, i_stat);
    assign w_next     = f_after(r_emit, i_stat);
    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_accept   = (r_state == ST_IDLE) && i_s_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.take     = w_accept;
        o_cmd.emit     = r_emit;
        o_cmd.out_last = (w_next == EMIT_NONE);
        unique case (r_state)
            ST_RD0: o_cmd.rd_ofs = OFS_LO;
            ST_RD1: begin
                o_cmd.rd_ofs  = OFS_MID;
                o_cmd.capture = 1'b1;
            end
            ST_RD2: begin
                o_cmd.rd_ofs  = OFS_HI;
                o_cmd.capture = 1'b1;
            end
            ST_RD3: begin
                o_cmd.capture = 1'b1;
                o_cmd.wr      = 1'b1;
            end
            ST_SEL:  o_cmd.load_op  = (r_emit != EMIT_NONE);
            ST_WAIT: o_cmd.out_load = !i_stat.norm_busy && w_out_free;
            ST_ADV:  o_cmd.advance  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_emit      <= EMIT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load)  r_out_valid <= 1'b1;
            else if (i_m_ready)  r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: if (w_accept) r_state <= ST_RD0;
                ST_RD0:  r_state <= ST_RD1;
                ST_RD1:  r_state <= ST_RD2;
                ST_RD2:  r_state <= ST_RD3;
                ST_RD3: begin
                    r_emit  <= w_first;
                    r_state <= ST_SEL;
                end
                ST_SEL: begin
                    r_state <= (r_emit == EMIT_NONE) ? ST_ADV : ST_WAIT;
                end
                ST_WAIT: begin
                    if (o_cmd.out_load) begin
                        r_emit  <= w_next;
                        r_state <= ST_SEL;
                    end
                end
                ST_ADV:  r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

### hdl/heightmap_normal_generator.sv
// heightmap normal generator, top level
// depends on hng_pkg, hng_ctrl, hng_datapath and heightmap_normal_generator_macros.svh
//
// usage:
// - heights enter on the s_axis channel in raster order, one 16-bit sample per item
// - normals leave on the m_axis channel with their grid coordinates; tlast marks the
//   final result caused by one input item
// - config is written through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle:
//   0 grid size, 1 height scale (q8.8), 2 cell size
// - results lag one row: the item at (c, r) finishes point (c, r-1); on the last row
//   it also finishes (c-1, r) and, at the last column, (c, r)
// - sequence: an item first reads the row buffers, on one port per buffer, and then runs the
//   shared normalizer (32-step square root, three 17-step divides) once per result it causes
// - one item is in work at a time; s_axis_tready is high only between items
// - the output register holds a result until taken; while the receiver stalls the next
//   result waits finished in the normalizer and no new item is taken
// - reset (synchronous, active low) restores config defaults and the position counters;
//   row buffers have no reset and are filled by the first rows of a frame
`include "heightmap_normal_generator_macros.svh"

module heightmap_normal_generator import hng_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [HEIGHT_W-1:0]   s_axis_tdata,   // [15:0] height
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z,
    // [57:48] point_col, [67:58] point_row, [71:68] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // last_of_run
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing of reads, buffer write, per-point normalization and output loads
    hng_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // row buffers, counters, normalizer and output register
    hng_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_height   (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

    // one item in work at a time
    `HNG_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")
    // a result is loaded only into a free or draining output register
    `HNG_ASSERT(a_load_free, w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
    // normalizer never runs while the input side is open
    `HNG_ASSERT(a_busy_closed, w_stat.norm_busy |-> !s_axis_tready, "input open during normalize")

endmodule

### test/heightmap_normal_generator_tb.sv
// self-checking testbench of the heightmap normal generator
// depends on hng_pkg and the heightmap_normal_generator rtl; predicts every normal in-line
`timescale 1ns / 100ps

module heightmap_normal_generator_tb;
    import hng_pkg::*;

    localparam int  MAX_SHOWN   = 10;
    localparam int  DRAIN_WAIT  = 300;
    localparam int  IDLE_WAIT   = 128;
    localparam longint CYCLE_LIMIT = 3000000;

    // one expected or observed normal
    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [9:0]         col;
        logic [9:0]         row;
        logic               last;
    } t_normal;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [HEIGHT_W-1:0]   s_axis_tdata = '0;   // [15:0] height
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z,
    // [57:48] point_col, [67:58] point_row
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;        // last_of_run

    heightmap_normal_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: the two row buffers, the position and the config
    logic [15:0] above_row [MAX_SIZE];    // row just before the current one
    logic [15:0] older_row [MAX_SIZE];    // row before that, also takes the current row
    int unsigned col_pos, row_pos;
    int unsigned grid_reg, scale_reg, cell_reg;

    t_normal     normal_expect_q[$];
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          hold_left = 0;           // long receiver hold-off, counted below
    longint      cycle_cnt = 0;

    // ---------------------------------------------------------------- prediction

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // round half away from zero of mag*32768/len, saturated to q1.15
    function automatic logic [15:0] to_q15(input longint unsigned mag, input bit neg,
                                           input longint unsigned len);
        longint unsigned q;
        q = (mag * 65536 + len) / (2 * len);
        if (!neg) return (q > 32767) ? 16'h7fff : q[15:0];
        if (q > 32768) q = 32768;
        return 16'(65536 - q);
    endfunction

    function automatic t_normal central_normal(input int unsigned c, input int unsigned r,
                                               input int unsigned lft, input int unsigned rgt,
                                               input int unsigned up, input int unsigned dn);
        t_normal         nv;
        longint          x, z;
        longint unsigned mx, my, mz, m, s, len;
        int              sh;
        x  = (longint'(lft) - longint'(rgt)) * longint'(scale_reg);
        z  = (longint'(up) - longint'(dn)) * longint'(scale_reg);
        mx = (x < 0) ? -x : x;
        my = longint'(cell_reg) * 256;
        mz = (z < 0) ? -z : z;
        m  = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        sh = 0;
        while ((m >> sh) >= (64'd1 << 30)) sh++;
        mx >>= sh;
        my >>= sh;
        mz >>= sh;
        s = mx * mx + my * my + mz * mz;
        if (s == 0) begin
            nv.nx = 0;
            nv.ny = 0;
            nv.nz = 0;
        end else begin
            len   = isqrt64(s);
            nv.nx = to_q15(mx, x < 0, len);
            nv.ny = to_q15(my, 1'b0, len);
            nv.nz = to_q15(mz, z < 0, len);
        end
        nv.col  = c[9:0];
        nv.row  = r[9:0];
        nv.last = 1'b0;
        return nv;
    endfunction

    function automatic int unsigned last_idx();
        int unsigned g;
        g = grid_reg;
        if (g < 2) g = 2;
        if (g > MAX_SIZE) g = MAX_SIZE;
        return g - 1;
    endfunction

    // advance the predictor by one accepted height and queue the normals it finishes
    function automatic void predict_normals(input logic [15:0] h);
        t_normal     found [3];
        int          n_found;
        int unsigned lim, c, r, self_h, lft, rgt, up;
        logic [15:0] tmp;
        lim = last_idx();
        c = col_pos;
        r = row_pos;
        n_found = 0;
        // the item finishes the point above it
        if (r >= 1) begin
            self_h = above_row[c];
            lft = (c == 0) ? self_h : above_row[c-1];
            rgt = (c >= lim) ? self_h : above_row[c+1];
            up  = (r == 1) ? self_h : older_row[c];
            found[n_found] = central_normal(c, r - 1, lft, rgt, up, h);
            n_found++;
        end
        older_row[c] = h;
        // on the last row it also finishes its left neighbour and, at the end, itself
        if (r >= lim) begin
            if (c >= 1) begin
                self_h = older_row[c-1];
                lft = (c == 1) ? self_h : older_row[c-2];
                found[n_found] = central_normal(c - 1, r, lft, h, above_row[c-1], self_h);
                n_found++;
            end
            if (c >= lim) begin
                lft = (c == 0) ? h : older_row[c-1];
                found[n_found] = central_normal(c, r, lft, h, above_row[c], h);
                n_found++;
            end
        end
        if (n_found > 0) found[n_found-1].last = 1'b1;
        for (int i = 0; i < n_found; i++)
            normal_expect_q.insert(normal_expect_q.size(), found[i]);
        // row end: buffers swap roles
        if (c >= lim) begin
            for (int i = 0; i < MAX_SIZE; i++) begin
                tmp = above_row[i];
                above_row[i] = older_row[i];
                older_row[i] = tmp;
            end
            col_pos = 0;
            row_pos = (r >= lim) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        t_normal seen, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.nx   = m_axis_tdata[15:0];
            seen.ny   = m_axis_tdata[31:16];
            seen.nz   = m_axis_tdata[47:32];
            seen.col  = m_axis_tdata[57:48];
            seen.row  = m_axis_tdata[67:58];
            seen.last = m_axis_tlast;
            if (normal_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected normal at (%0d,%0d)", seen.col, seen.row);
            end else begin
                want = normal_expect_q.pop_front();
                if (seen.nx !== want.nx || seen.ny !== want.ny || seen.nz !== want.nz ||
                    seen.col !== want.col || seen.row !== want.row ||
                    seen.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch: expected n=(%0d,%0d,%0d) at (%0d,%0d) last %0d",
                                 want.nx, want.ny, want.nz, want.col, want.row, want.last);
                        $display("          got      n=(%0d,%0d,%0d) at (%0d,%0d) last %0d",
                                 seen.nx, seen.ny, seen.nz, seen.col, seen.row, seen.last);
                    end
                end
            end
        end
    end

    // receiver: random stalls, or a solid hold-off while hold_left runs down
    always @(negedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** heightmap_normal_generator: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_GRID_SIZE:    grid_reg  = val & 16'h07ff;
            REG_HEIGHT_SCALE: scale_reg = val & 16'hffff;
            REG_CELL_SIZE:    cell_reg  = val & 16'hffff;
            default: ;
        endcase
    endtask

    // offer one height, with random gaps, until the block takes it
    task automatic send_height(input logic [15:0] h);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = h;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_normals(h);
    endtask

    // stop offering, wait for every expected normal and let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (normal_expect_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_coef();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 16'hffff;
            2:       return $urandom_range(64, 1024);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // one full frame of heights in a random style
    task automatic send_frame(input int unsigned g);
        int unsigned style, base;
        logic [15:0] h;
        style = $urandom_range(4);
        base  = $urandom_range(65535);
        for (int i = 0; i < g * g; i++) begin
            case (style)
                0:       h = $urandom_range(65535);
                1:       h = 16'(base + $urandom_range(64));          // small random variation
                2:       h = base[15:0];                              // flat
                3:       h = $urandom_range(1) ? 16'hffff : 16'h0000; // cliffs
                default: h = 16'(base + i * $urandom_range(300));
            endcase
            send_height(h);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // extremes: zero length, max coefficients, tiny grids with out-of-range sizes
    task automatic test_directed();
        wait_idle();
        write_reg(REG_GRID_SIZE, 0);        // clamps to 2
        write_reg(REG_HEIGHT_SCALE, 0);
        write_reg(REG_CELL_SIZE, 0);
        send_height(16'h1234); send_height(16'hffff);
        send_height(16'h0000); send_height(16'h8000);
        wait_idle();
        write_reg(REG_GRID_SIZE, 1);        // clamps to 2
        write_reg(REG_HEIGHT_SCALE, 16'hffff);
        send_height(16'h0000); send_height(16'hffff);
        send_height(16'hffff); send_height(16'h0000);
        wait_idle();
        write_reg(REG_GRID_SIZE, 3);
        write_reg(REG_HEIGHT_SCALE, 256);
        write_reg(REG_CELL_SIZE, 16'hffff);
        for (int i = 0; i < 9; i++) send_height(16'(i * 7000));
        wait_idle();
        write_reg(REG_GRID_SIZE, 2);
        write_reg(REG_CELL_SIZE, 1);
        write_reg(REG_HEIGHT_SCALE, 16'hffff);
        send_height(16'hffff); send_height(16'h0000); send_height(16'h5555);
        send_height(16'haaaa);
        wait_idle();
    endtask

    // random frames under one idling pattern
    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int item_goal);
        int unsigned g, sent;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_goal) begin
            wait_idle();
            g = ($urandom_range(4) != 0) ? $urandom_range(2, 5) : $urandom_range(6, 9);
            write_reg(REG_GRID_SIZE, g);
            write_reg(REG_HEIGHT_SCALE, pick_coef());
            write_reg(REG_CELL_SIZE, pick_coef());
            send_frame(g);
            sent += g * g;
        end
        wait_idle();
    endtask

    // receiver holds off while heights keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        wait_idle();
        write_reg(REG_GRID_SIZE, 4);
        write_reg(REG_HEIGHT_SCALE, pick_coef());
        write_reg(REG_CELL_SIZE, pick_coef());
        hold_left = 3000;
        send_frame(4);
        wait_idle();
    endtask

    initial begin
        col_pos   = 0;
        row_pos   = 0;
        grid_reg  = GRID_RESET;
        scale_reg = SCALE_RESET;
        cell_reg  = CELL_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_frames(0, 0, 60);
        test_random_frames(53, 0, 55);
        test_random_frames(0, 53, 55);
        test_random_frames(15, 15, 55);
        test_backpressure();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && normal_expect_q.size() == 0) begin
            $display("** heightmap_normal_generator: PASSED **");
        end else begin
            $display("** heightmap_normal_generator: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/hng_pkg.sv
hdl/hng_norm.sv
hdl/hng_datapath.sv
hdl/hng_ctrl.sv
hdl/heightmap_normal_generator.sv
test/heightmap_normal_generator_tb.sv
